@@ rtl/spsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the slotted page space manager.
// No dependencies; used by the top level.
package spsm_pkg;

  localparam int CALC_W     = 20;
  localparam int PAGE_RESET = 4096;

  typedef logic signed [CALC_W-1:0] calc_t;

  typedef enum logic [2:0] {
    OP_FORMAT   = 3'd0,
    OP_FITS_INS = 3'd1,
    OP_FITS_UPD = 3'd2,
    OP_INSERT   = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_UPD_INPL = 3'd5,
    OP_UPD_RELO = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NO_SPACE = 3'd1,
    STS_BAD_SLOT = 3'd2,
    STS_NOT_PAGE = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TID_NONE  = 2'd0,
    TID_WRITE = 2'd1,
    TID_MOVE  = 2'd2
  } tid_act_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam logic REG_PAGE_SIZE = 1'b0;

  typedef struct packed {
    logic [15:0] offset;
    logic [14:0] length;
    logic        on_page;
    logic        redir;
  } slot_t;

endpackage

@@ rtl/spsm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot table.
module spsm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/slotted_page_space_manager_unit.sv @@
`timescale 1ns / 1ps
// Slotted page space manager: one request in, one registered result out.
// A request is taken and its slot entry read in IDLE, and no other until back
// in IDLE; in EXEC, held while the output stalls, any slot update is written
// and the result registered. Reset: page size 4096, page formatted; slot
// table keeps its contents and takes no clearing pass. Depends on spsm_pkg and spsm_ram.
module slotted_page_space_manager_unit #(
  parameter int MAX_SLOTS        = 256,
  parameter int MIN_RECORD_BYTES = 8,
  parameter int SLOT_BYTES       = 8,
  parameter int HEADER_BYTES     = 32,
  parameter int TID_BYTES        = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  slot_index_i,
  input  logic [14:0] record_length_i,
  input  logic        redirected_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  slot_number_o,
  output logic [14:0] record_offset_o,
  output logic [14:0] tid_offset_o,
  output logic [14:0] old_tid_offset_o,
  output logic [1:0]  tid_action_o,
  output logic [14:0] free_bytes_o
);

  localparam int AW   = $clog2(MAX_SLOTS);
  localparam int NS_W = $clog2(MAX_SLOTS + 1);

  localparam spsm_pkg::calc_t MIN_C  = spsm_pkg::calc_t'(MIN_RECORD_BYTES);
  localparam spsm_pkg::calc_t SLOT_C = spsm_pkg::calc_t'(SLOT_BYTES);
  localparam spsm_pkg::calc_t HDR_C  = spsm_pkg::calc_t'(HEADER_BYTES);
  localparam spsm_pkg::calc_t TID_C  = spsm_pkg::calc_t'(TID_BYTES);
  localparam spsm_pkg::calc_t MAX_C  = spsm_pkg::calc_t'(MAX_SLOTS);
  localparam spsm_pkg::calc_t FMAX_C = spsm_pkg::calc_t'(32767);

  function automatic logic [14:0] clamp_free(input spsm_pkg::calc_t v);
    logic [14:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > FMAX_C) begin
      r = 15'h7fff;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  spsm_pkg::state_e state_q, state_d;

  logic        in_fire;
  logic        exec_go;
  logic        cfg_we;

  logic [15:0]     page_size_q;
  logic [NS_W-1:0] next_slot_q, next_slot_d;
  logic [15:0]     data_start_q, data_start_d;
  logic [14:0]     free_q, free_d;

  logic [2:0]  op_q;
  logic [7:0]  idx_q;
  logic [14:0] len_q;
  logic        redir_q;

  logic        out_valid_q;
  logic [2:0]  status_q, status_d;
  logic [7:0]  slot_num_q, slot_num_d;
  logic [14:0] roff_q, roff_d;
  logic [14:0] toff_q, toff_d;
  logic [14:0] otoff_q, otoff_d;
  logic [1:0]  act_q, act_d;

  spsm_pkg::slot_t ent;
  spsm_pkg::slot_t wr_ent;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  spsm_pkg::calc_t idx_in_ext, idx_ext, ns_ext;
  spsm_pkg::calc_t pad, old_pad, tid_req, stid, gap, need, off, ds_ext, fr_ext;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == spsm_pkg::REG_PAGE_SIZE);
  assign prdata = (paddr[2] == spsm_pkg::REG_PAGE_SIZE) ? {16'h0, page_size_q} : 32'h0;

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      spsm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spsm_pkg::ST_EXEC;
      end
      spsm_pkg::ST_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = spsm_pkg::ST_IDLE;
      end
      default: state_d = spsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exec_go    = 1'b0;
    case (state_q)
      spsm_pkg::ST_IDLE: in_ready_o = 1'b1;
      spsm_pkg::ST_EXEC: exec_go = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // slot table
  assign idx_in_ext = spsm_pkg::calc_t'(slot_index_i);
  assign rd_addr    = idx_in_ext[AW-1:0];

  spsm_ram #(
    .WIDTH($bits(spsm_pkg::slot_t)),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_ent),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(ent)
  );

  // execute
  assign idx_ext = spsm_pkg::calc_t'(idx_q);
  assign ns_ext  = spsm_pkg::calc_t'(next_slot_q);
  assign ds_ext  = spsm_pkg::calc_t'(data_start_q);
  assign fr_ext  = spsm_pkg::calc_t'(free_q);
  assign pad     = (spsm_pkg::calc_t'(len_q) < MIN_C) ? MIN_C : spsm_pkg::calc_t'(len_q);
  assign old_pad = (spsm_pkg::calc_t'(ent.length) < MIN_C) ? MIN_C
                                                           : spsm_pkg::calc_t'(ent.length);
  assign tid_req = redir_q ? TID_C : '0;
  assign stid    = ent.redir ? TID_C : '0;
  assign gap     = ds_ext - HDR_C - ns_ext * SLOT_C;

  always_comb begin
    status_d     = spsm_pkg::STS_OK;
    slot_num_d   = '0;
    roff_d       = '0;
    toff_d       = '0;
    otoff_d      = '0;
    act_d        = spsm_pkg::TID_NONE;
    next_slot_d  = next_slot_q;
    data_start_d = data_start_q;
    free_d       = free_q;
    wr_en        = 1'b0;
    wr_addr      = idx_ext[AW-1:0];
    wr_ent       = '0;
    need         = '0;
    off          = '0;
    case (op_q)
      spsm_pkg::OP_FORMAT: begin
        next_slot_d  = '0;
        data_start_d = page_size_q;
        free_d       = clamp_free(spsm_pkg::calc_t'(page_size_q) - HDR_C);
      end
      spsm_pkg::OP_FITS_INS: begin
        need = pad + SLOT_C;
        if (ns_ext >= MAX_C) begin
          status_d = spsm_pkg::STS_FULL;
        end else if (fr_ext < need || gap < need) begin
          status_d = spsm_pkg::STS_NO_SPACE;
        end
      end
      spsm_pkg::OP_FITS_UPD: begin
        if (gap < pad) status_d = spsm_pkg::STS_NO_SPACE;
      end
      spsm_pkg::OP_INSERT: begin
        need = pad + tid_req + SLOT_C;
        off  = ds_ext - pad;
        if (ns_ext >= MAX_C) begin
          status_d = spsm_pkg::STS_FULL;
        end else if (fr_ext < need || gap < need) begin
          status_d = spsm_pkg::STS_NO_SPACE;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = ns_ext[AW-1:0];
          wr_ent.offset  = off[15:0];
          wr_ent.length  = len_q;
          wr_ent.on_page = 1'b1;
          wr_ent.redir   = redir_q;
          next_slot_d    = next_slot_q + NS_W'(1);
          data_start_d   = 16'(off - tid_req);
          free_d         = clamp_free(fr_ext - need);
          slot_num_d     = ns_ext[7:0];
          roff_d         = off[14:0];
          if (redir_q) begin
            toff_d = 15'(off - TID_C);
            act_d  = spsm_pkg::TID_WRITE;
          end
        end
      end
      spsm_pkg::OP_REMOVE, spsm_pkg::OP_UPD_INPL, spsm_pkg::OP_UPD_RELO: begin
        slot_num_d = idx_q;
        if (idx_ext >= ns_ext) begin
          status_d = spsm_pkg::STS_BAD_SLOT;
        end else if (!ent.on_page) begin
          status_d = spsm_pkg::STS_NOT_PAGE;
        end else if (op_q == spsm_pkg::OP_REMOVE) begin
          wr_en  = 1'b1;
          free_d = clamp_free(fr_ext + SLOT_C + old_pad + stid);
        end else if (op_q == spsm_pkg::OP_UPD_INPL) begin
          off = spsm_pkg::calc_t'(ent.offset) + old_pad - pad;
          if (pad > old_pad) begin
            status_d = spsm_pkg::STS_NOT_PAGE;
          end else begin
            wr_en          = 1'b1;
            wr_ent.offset  = off[15:0];
            wr_ent.length  = len_q;
            wr_ent.on_page = 1'b1;
            wr_ent.redir   = ent.redir;
            free_d         = clamp_free(fr_ext + old_pad - pad);
            roff_d         = off[14:0];
            if (ent.redir) begin
              toff_d  = 15'(off - TID_C);
              otoff_d = 15'(spsm_pkg::calc_t'(ent.offset) - TID_C);
              act_d   = spsm_pkg::TID_MOVE;
            end
          end
        end else begin
          off = ds_ext - pad;
          if (gap < pad + stid) begin
            status_d = spsm_pkg::STS_NO_SPACE;
          end else begin
            wr_en          = 1'b1;
            wr_ent.offset  = off[15:0];
            wr_ent.length  = len_q;
            wr_ent.on_page = 1'b1;
            wr_ent.redir   = ent.redir;
            data_start_d   = 16'(off - stid);
            free_d         = clamp_free(fr_ext + old_pad - pad);
            roff_d         = off[14:0];
            if (ent.redir) begin
              toff_d  = 15'(off - TID_C);
              otoff_d = 15'(spsm_pkg::calc_t'(ent.offset) - TID_C);
              act_d   = spsm_pkg::TID_MOVE;
            end
          end
        end
      end
      default: status_d = spsm_pkg::STS_NOT_PAGE;
    endcase
    if (!exec_go) wr_en = 1'b0;
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spsm_pkg::ST_IDLE;
      page_size_q  <= 16'(spsm_pkg::PAGE_RESET);
      next_slot_q  <= '0;
      data_start_q <= 16'(spsm_pkg::PAGE_RESET);
      free_q       <= 15'(spsm_pkg::PAGE_RESET - HEADER_BYTES);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) page_size_q <= pwdata[15:0];
      if (exec_go) begin
        next_slot_q  <= next_slot_d;
        data_start_q <= data_start_d;
        free_q       <= free_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= opcode_i;
      idx_q   <= slot_index_i;
      len_q   <= record_length_i;
      redir_q <= redirected_i;
    end
    if (exec_go) begin
      status_q   <= status_d;
      slot_num_q <= slot_num_d;
      roff_q     <= roff_d;
      toff_q     <= toff_d;
      otoff_q    <= otoff_d;
      act_q      <= act_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_number_o    = slot_num_q;
  assign record_offset_o  = roff_q;
  assign tid_offset_o     = toff_q;
  assign old_tid_offset_o = otoff_q;
  assign tid_action_o     = act_q;
  assign free_bytes_o     = free_q;

endmodule
